FILE: rtl/core/jsu_pkg.sv
// Shared types, codes and helpers of the JSON string unescaper.
package jsu_pkg;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam logic [2:0] ERR_BAD_ESC    = 3'd0;
  localparam logic [2:0] ERR_BAD_HEX    = 3'd1;
  localparam logic [2:0] ERR_CTRL       = 3'd2;
  localparam logic [2:0] ERR_UNTERM_STR = 3'd3;
  localparam logic [2:0] ERR_UNTERM_UNI = 3'd4;

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  hex_count;
    logic [15:0] code_accum;
  } st_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] code;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } dec_t;

  // {valid, value} of one ASCII hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      v = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b1, 4'(c - 8'h37)};
    return v;
  endfunction

endpackage

FILE: rtl/core/jsu_in_if.sv
// Input channel: one raw stream byte or an end-of-stream mark per transaction.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

FILE: rtl/core/jsu_out_if.sv
// Result channel: one decoded byte, close mark or error per transaction.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input error_code,
                  input last, output ready);
endinterface

FILE: rtl/core/jsu_decoder.sv
// Next-state and result logic for one input transaction.
module jsu_decoder (
  input  jsu_pkg::st_t  st,
  input  logic [7:0]    in_byte,
  input  logic          stream_end,
  output jsu_pkg::st_t  st_nxt,
  output jsu_pkg::dec_t dec
);
  import jsu_pkg::*;

  logic [4:0]  hv;
  logic [15:0] cp;
  logic [7:0]  esc_byte;
  logic        esc_ok;

  function automatic res_t mk(input logic [1:0] k, input logic [7:0] d,
                              input logic [2:0] c);
    res_t r;
    r.kind = k;
    r.data = d;
    r.code = c;
    return r;
  endfunction

  assign hv = hex_val(in_byte);
  assign cp = {st.code_accum[11:0], hv[3:0]};

  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_byte;
    case (in_byte) inside
      8'h22, 8'h5C, 8'h2F: esc_byte = in_byte;
      8'h62:               esc_byte = 8'h08;
      8'h66:               esc_byte = 8'h0C;
      8'h6E:               esc_byte = 8'h0A;
      8'h72:               esc_byte = 8'h0D;
      8'h74:               esc_byte = 8'h09;
      default:             esc_ok   = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt = st;
    dec.n  = 2'd0;
    dec.r0 = mk(KIND_DATA, 8'h00, 3'd0);
    dec.r1 = mk(KIND_DATA, 8'h00, 3'd0);
    dec.r2 = mk(KIND_DATA, 8'h00, 3'd0);
    if (stream_end) begin
      if (st.mode != MODE_IDLE) begin
        dec.n  = 2'd1;
        dec.r0 = mk(KIND_ERR, 8'h00,
                    (st.mode == MODE_HEX) ? ERR_UNTERM_UNI : ERR_UNTERM_STR);
        st_nxt = '0;
      end
    end else begin
      unique case (st.mode)
        MODE_IDLE: begin
          if (in_byte == 8'h22) st_nxt.mode = MODE_STR;
        end
        MODE_STR: begin
          if (in_byte == 8'h5C) begin
            st_nxt.mode = MODE_ESC;
          end else if (in_byte == 8'h22) begin
            dec.n       = 2'd1;
            dec.r0      = mk(KIND_CLOSE, 8'h00, 3'd0);
            st_nxt.mode = MODE_IDLE;
          end else if (in_byte < 8'h20) begin
            dec.n  = 2'd1;
            dec.r0 = mk(KIND_ERR, 8'h00, ERR_CTRL);
            st_nxt = '0;
          end else begin
            dec.n  = 2'd1;
            dec.r0 = mk(KIND_DATA, in_byte, 3'd0);
          end
        end
        MODE_ESC: begin
          if (in_byte == 8'h75) begin
            st_nxt.mode       = MODE_HEX;
            st_nxt.hex_count  = 2'd0;
            st_nxt.code_accum = 16'h0000;
          end else if (esc_ok) begin
            dec.n       = 2'd1;
            dec.r0      = mk(KIND_DATA, esc_byte, 3'd0);
            st_nxt.mode = MODE_STR;
          end else begin
            dec.n  = 2'd1;
            dec.r0 = mk(KIND_ERR, 8'h00, ERR_BAD_ESC);
            st_nxt = '0;
          end
        end
        MODE_HEX: begin
          if (!hv[4]) begin
            dec.n  = 2'd1;
            dec.r0 = mk(KIND_ERR, 8'h00, ERR_BAD_HEX);
            st_nxt = '0;
          end else if (st.hex_count != 2'd3) begin
            st_nxt.code_accum = cp;
            st_nxt.hex_count  = st.hex_count + 2'd1;
          end else begin
            st_nxt.mode       = MODE_STR;
            st_nxt.hex_count  = 2'd0;
            st_nxt.code_accum = 16'h0000;
            if (cp[15:7] == 9'd0) begin
              dec.n  = 2'd1;
              dec.r0 = mk(KIND_DATA, cp[7:0], 3'd0);
            end else if (cp[15:11] == 5'd0) begin
              dec.n  = 2'd2;
              dec.r0 = mk(KIND_DATA, {3'b110, cp[10:6]}, 3'd0);
              dec.r1 = mk(KIND_DATA, {2'b10, cp[5:0]}, 3'd0);
            end else begin
              dec.n  = 2'd3;
              dec.r0 = mk(KIND_DATA, {4'b1110, cp[15:12]}, 3'd0);
              dec.r1 = mk(KIND_DATA, {2'b10, cp[11:6]}, 3'd0);
              dec.r2 = mk(KIND_DATA, {2'b10, cp[5:0]}, 3'd0);
            end
          end
        end
        default: st_nxt = '0;
      endcase
    end
  end

endmodule

FILE: rtl/core/json_string_unescaper_unit.sv
// JSON string unescaper: raw byte stream in, decoded UTF-8 bytes and marks out.
//
// in_ch carries one raw byte (or a stream_end mark) per transaction. While
// idle the block waits for an opening quote; inside a string it passes bytes,
// decodes escapes and turns \uXXXX into one to three UTF-8 bytes.
// out_ch carries one result per transaction: a data byte, a string-closed
// mark or an error; last flags the final result caused by one input.
// Results are registered and reach out_ch the cycle after their byte is taken.
// Throughput: one input byte per cycle while each byte yields at most one
// result and out_ch.ready stays high. A \u escape that yields two or three
// bytes holds in_ch.ready low while the three-entry result buffer drains.
// Inputs that yield no result (opening quote, backslash, hex digits) leave
// the buffer empty. A stalled receiver holds the current result; in_ch.ready
// then stays low unless the buffer holds only its final result and
// out_ch.ready is high. Reset (rst_n low, synchronous) returns the decoder to
// idle and empties the result buffer.
module json_string_unescaper_unit (
  input logic      clk,
  input logic      rst_n,
  jsu_in_if.sink   in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  st_t        st_r, st_nxt;
  dec_t       dec;
  res_t       res_r [MAX_RES];
  res_t       res_nxt [MAX_RES];
  logic [1:0] cnt_r, cnt_nxt;
  logic       take, pop;

  jsu_decoder u_dec (
    .st        (st_r),
    .in_byte   (in_ch.in_byte),
    .stream_end(in_ch.stream_end),
    .st_nxt    (st_nxt),
    .dec       (dec)
  );

  assign pop         = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    if (take) begin
      res_nxt[0] = dec.r0;
      res_nxt[1] = dec.r1;
      res_nxt[2] = dec.r2;
      cnt_nxt    = dec.n;
    end else if (pop) begin
      // advance the remaining UTF-8 bytes
      res_nxt[0] = res_r[1];
      res_nxt[1] = res_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      cnt_r <= 2'd0;
    end else begin
      if (take) st_r <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid      = (cnt_r != 2'd0);
  assign out_ch.kind       = res_r[0].kind;
  assign out_ch.out_byte   = res_r[0].data;
  assign out_ch.error_code = res_r[0].code;
  assign out_ch.last       = (cnt_r == 2'd1);

endmodule

FILE: rtl/core/jsu_checker.sv
// Port-level checks of the JSON string unescaper, bound to the top level.
module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic [2:0] out_error_code,
  input logic       out_last
);
  import jsu_pkg::*;

  // a stalled transaction stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_CLOSE || out_kind == KIND_ERR) |-> out_last)
    else $error("close or error result not marked last");

  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_DATA) ? (out_error_code == 3'd0)
                                          : (out_byte == 8'h00))
    else $error("unused result field not zero");

  // pending UTF-8 bytes block the input side
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken while a multi-byte result drains");

endmodule

bind json_string_unescaper_unit jsu_checker u_jsu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_kind      (out_ch.kind),
  .out_byte      (out_ch.out_byte),
  .out_error_code(out_ch.error_code),
  .out_last      (out_ch.last)
);
